[sv/afd_pkg.sv]
// ----------------------------------------------------------------------------
// afd_pkg: shared types and constants for the adts frame deframer
// Sync bytes, header geometry, length limits and the queue entry format
// that is passed from the parser front end to the output back end.
// ----------------------------------------------------------------------------
package afd_pkg;

   // adts sync pattern and header layout
   localparam logic [7:0]  SyncByte     = 8'hFF;
   localparam logic [7:0]  SyncHiMask   = 8'hF0;
   localparam int          HdrBytes     = 6;
   localparam int          HdrIdxW      = $clog2(HdrBytes);
   localparam logic [HdrIdxW-1:0] HdrLastIdx = HdrIdxW'(HdrBytes - 1);

   // frame length limits
   localparam int          LenW         = 13;
   localparam logic [LenW-1:0] MinLen      = LenW'(7);
   localparam logic [LenW-1:0] MaxLenReset = LenW'(1024 * 5);

   // work queue between front and back
   localparam int          QueueDepth   = 8;
   localparam int          QueuePtrW    = $clog2(QueueDepth);

   typedef enum logic {
      OP_HEADER,
      OP_BODY
   } op_kind_type;

   // header ops carry all six header bytes, body ops use byte 0 only
   typedef struct packed {
      op_kind_type                  kind;
      logic [HdrBytes-1:0][7:0]     bytes;
      logic                         last;
      logic [LenW-1:0]              length;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[sv/afd_front.sv]
// ----------------------------------------------------------------------------
// afd_front: sync hunt and header parser
// Takes one stream byte per transfer, tracks sync and header collection,
// checks the frame length and pushes header and body ops into the queue.
// ----------------------------------------------------------------------------
module afd_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_data_byte,
   input  logic                     csr_wr_en,
   input  logic [afd_pkg::LenW-1:0] csr_wr_data,
   input  afd_pkg::queue_status_type q_status,
   output logic                     q_push,
   output afd_pkg::queue_entry_type q_entry
);

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_HEAD = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   phase_type                  phase_ff, phase_in;
   logic [2:0]                 hdr_cnt_ff, hdr_cnt_in;
   logic [afd_pkg::LenW-1:0]   left_ff, left_in;
   logic [afd_pkg::LenW-1:0]   cur_len_ff, cur_len_in;
   logic [afd_pkg::LenW-1:0]   max_len_ff;
   logic [7:0]                 hdr_ff [afd_pkg::HdrBytes];
   logic [7:0]                 hdr_in [afd_pkg::HdrBytes];
   logic                       accept;
   logic [afd_pkg::LenW-1:0]   len;
   logic [afd_pkg::LenW-1:0]   left_dec;

   // input transfer happens whenever the queue has room
   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   // length field: low two bits of byte 3, byte 4, top three bits of byte 5
   assign len = {hdr_ff[3][1:0], hdr_ff[4], req_data_byte[7:5]};
   assign left_dec = (left_ff != '0) ? left_ff - afd_pkg::LenW'(1) : left_ff;

   // next state and queue push
   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      left_in    = left_ff;
      cur_len_in = cur_len_ff;
      hdr_in     = hdr_ff;
      q_push     = 1'b0;
      q_entry.kind   = afd_pkg::OP_BODY;
      q_entry.bytes  = '0;
      q_entry.bytes[0] = req_data_byte;
      q_entry.last   = 1'b0;
      q_entry.length = cur_len_ff;
      if (accept) begin
         case (phase_ff)
            PH_HEAD: begin
               if (hdr_cnt_ff == 3'd1) begin
                  if ((req_data_byte & afd_pkg::SyncHiMask) == afd_pkg::SyncHiMask) begin
                     hdr_in[1]  = req_data_byte;
                     hdr_cnt_in = 3'd2;
                  end else begin
                     phase_in   = PH_HUNT;
                     hdr_cnt_in = 3'd0;
                  end
               end else if (hdr_cnt_ff >= 3'd2 && hdr_cnt_ff < 3'(afd_pkg::HdrBytes - 1)) begin
                  hdr_in[hdr_cnt_ff] = req_data_byte;
                  hdr_cnt_in = hdr_cnt_ff + 3'd1;
               end else if (hdr_cnt_ff == 3'(afd_pkg::HdrBytes - 1)) begin
                  // last header byte: check the length and release the header
                  hdr_in[hdr_cnt_ff] = req_data_byte;
                  hdr_cnt_in = 3'd0;
                  if (len < afd_pkg::MinLen || len > max_len_ff) begin
                     phase_in = PH_HUNT;
                  end else begin
                     phase_in   = PH_BODY;
                     cur_len_in = len;
                     left_in    = len - afd_pkg::LenW'(afd_pkg::HdrBytes);
                     q_push     = 1'b1;
                     q_entry.kind  = afd_pkg::OP_HEADER;
                     q_entry.bytes = {req_data_byte, hdr_ff[4], hdr_ff[3],
                                      hdr_ff[2], hdr_ff[1], hdr_ff[0]};
                     q_entry.length = len;
                  end
               end else begin
                  phase_in   = PH_HUNT;
                  hdr_cnt_in = 3'd0;
               end
            end
            PH_BODY: begin
               left_in      = left_dec;
               q_push       = 1'b1;
               q_entry.last = (left_dec == '0);
               if (left_dec == '0) begin
                  phase_in = PH_HUNT;
               end
            end
            default: begin
               phase_in = PH_HUNT;
               if (req_data_byte == afd_pkg::SyncByte) begin
                  hdr_in[0]  = req_data_byte;
                  hdr_cnt_in = 3'd1;
                  phase_in   = PH_HEAD;
               end
            end
         endcase
      end
   end

   // control state and length limit
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         hdr_cnt_ff <= 3'd0;
         left_ff    <= '0;
         cur_len_ff <= '0;
         max_len_ff <= afd_pkg::MaxLenReset;
      end else begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         left_ff    <= left_in;
         cur_len_ff <= cur_len_in;
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
      end
   end

   // held header bytes
   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

endmodule

[sv/afd_queue.sv]
// ----------------------------------------------------------------------------
// afd_queue: small op queue between front and back
// Register based fifo; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module afd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  afd_pkg::queue_entry_type  push_entry,
   input  logic                      pop,
   output afd_pkg::queue_entry_type  head,
   output afd_pkg::queue_status_type status
);

   afd_pkg::queue_entry_type        mem_ff [afd_pkg::QueueDepth];
   logic [afd_pkg::QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [afd_pkg::QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [afd_pkg::QueuePtrW:0]     cnt_ff, cnt_in;
   logic                            do_push, do_pop;

   assign status.full  = (cnt_ff == (afd_pkg::QueuePtrW+1)'(afd_pkg::QueueDepth));
   assign status.empty = (cnt_ff == '0);
   assign head         = mem_ff[rd_ptr_ff];

   // guarded pointer updates
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[sv/afd_back.sv]
// ----------------------------------------------------------------------------
// afd_back: result sequencer
// Turns queued ops into result transfers: a header op expands into six
// bytes, a body op into one. Results sit in an output register.
// ----------------------------------------------------------------------------
module afd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  afd_pkg::queue_entry_type  head,
   input  afd_pkg::queue_status_type q_status,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_frame_byte,
   output logic                      rsp_first_of_frame,
   output logic                      rsp_last_of_frame,
   output logic [afd_pkg::LenW-1:0]  rsp_length_of_frame
);

   logic [afd_pkg::HdrIdxW-1:0] idx_ff, idx_in;
   logic                        valid_ff, valid_in;
   logic [7:0]                  byte_ff, byte_in;
   logic                        first_ff, first_in;
   logic                        last_ff, last_in;
   logic [afd_pkg::LenW-1:0]    len_ff, len_in;
   logic                        load;
   logic                        take;
   logic                        is_hdr;

   // output register may load when empty or being taken
   assign load   = !valid_ff || !rsp_stall;
   assign take   = load && !q_status.empty;
   assign is_hdr = (head.kind == afd_pkg::OP_HEADER);
   assign q_pop  = take && (!is_hdr || idx_ff == afd_pkg::HdrLastIdx);

   // result selection and header byte index
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      first_in = first_ff;
      last_in  = last_ff;
      len_in   = len_ff;
      if (load) begin
         valid_in = !q_status.empty;
      end
      if (take) begin
         len_in = head.length;
         if (is_hdr) begin
            byte_in  = head.bytes[idx_ff];
            first_in = (idx_ff == '0);
            last_in  = 1'b0;
            idx_in   = (idx_ff == afd_pkg::HdrLastIdx) ? '0 : idx_ff + 1'b1;
         end else begin
            byte_in  = head.bytes[0];
            first_in = 1'b0;
            last_in  = head.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      len_ff   <= len_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_frame_byte      = byte_ff;
   assign rsp_first_of_frame  = first_ff;
   assign rsp_last_of_frame   = last_ff;
   assign rsp_length_of_frame = len_ff;

endmodule

[sv/adts_frame_deframer.sv]
// Path: a body byte passes through the op queue and then the output register
//   before it appears on rsp; the six header bytes take the same path.
// Throughput: one input byte and one result per cycle unless stalled; the 8-entry
//   op queue absorbs the six-result header burst while body bytes keep arriving.
// Reset: synchronous, active high; clears parser, queue and output valid,
//   and sets the maximum frame length to 5120.
// ----------------------------------------------------------------------------
// adts_frame_deframer: adts sync search and frame extraction
// Front end hunts sync and parses the header, back end streams frame bytes
// with first and last marks; a short op queue sits between them.
// ----------------------------------------------------------------------------
module adts_frame_deframer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_data_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_frame_byte,
   output logic                     rsp_first_of_frame,
   output logic                     rsp_last_of_frame,
   output logic [afd_pkg::LenW-1:0] rsp_length_of_frame,
   input  logic                     csr_wr_en,
   input  logic [afd_pkg::LenW-1:0] csr_wr_data
);

   afd_pkg::queue_status_type q_status;
   afd_pkg::queue_entry_type  q_entry;
   afd_pkg::queue_entry_type  q_head;
   logic                      q_push;
   logic                      q_pop;

   // parser front end
   afd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   // op queue
   afd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   // result back end
   afd_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (q_head),
      .q_status            (q_status),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_byte      (rsp_frame_byte),
      .rsp_first_of_frame  (rsp_first_of_frame),
      .rsp_last_of_frame   (rsp_last_of_frame),
      .rsp_length_of_frame (rsp_length_of_frame)
   );

   // front never pushes into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full))
      else $error("push into full op queue");

   // back never pops an empty queue
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_status.empty))
      else $error("pop from empty op queue");

   // a frame byte is never both first and last
   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_first_of_frame && rsp_last_of_frame))
      else $error("result marked first and last");

   // every emitted frame has a length no shorter than the minimum
   a_len_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_length_of_frame >= afd_pkg::MinLen))
      else $error("result with frame length below minimum");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the adts frame deframer
// Drives raw bytes into the parser and runs a bit-exact predictor of the sync
// search, the header parse and the frame pass-through next to it. Every
// output transfer is checked field by field against the oldest predicted
// byte. Covers directed sync and length cases, limit register extremes,
// long output back-pressure and a long random stream under bursty traffic.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned DrainLimit  = 50000;
   localparam int unsigned MaxPrinted  = 40;
   localparam int unsigned RandomItems = 200;

   // parser phases of the predictor
   typedef enum logic [1:0] {
      HUNTING,
      IN_HEADER,
      IN_BODY
   } parse_phase_type;

   // one predicted output byte
   typedef struct packed {
      logic [7:0]               data;
      logic                     first;
      logic                     last;
      logic [afd_pkg::LenW-1:0] length;
   } frame_byte_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [7:0]               req_data_byte;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [7:0]               rsp_frame_byte;
   logic                     rsp_first_of_frame;
   logic                     rsp_last_of_frame;
   logic [afd_pkg::LenW-1:0] rsp_length_of_frame;
   logic                     csr_wr_en;
   logic [afd_pkg::LenW-1:0] csr_wr_data;

   // predictor state
   parse_phase_type          parse_phase;
   logic [7:0]               hdr_hold [afd_pkg::HdrBytes];
   int unsigned              hdr_count;
   logic [afd_pkg::LenW-1:0] body_left;
   logic [afd_pkg::LenW-1:0] cur_len;
   logic [afd_pkg::LenW-1:0] max_len;

   frame_byte_type  frame_expect_q [$];
   logic [7:0]      stream_q [$];
   int unsigned     mismatch_count;

   // traffic shaping knobs
   int unsigned     gap_max;
   int unsigned     burst_left;
   int unsigned     stall_pct;
   int unsigned     hold_cycles;

   adts_frame_deframer DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_byte      (rsp_frame_byte),
      .rsp_first_of_frame  (rsp_first_of_frame),
      .rsp_last_of_frame   (rsp_last_of_frame),
      .rsp_length_of_frame (rsp_length_of_frame),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   // clock, period 20
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MaxPrinted) begin
         $display("mismatch at %0t: %s", $time, what);
      end
   endtask

   function automatic void expect_byte(input logic [7:0] b, input logic first,
                                       input logic last);
      frame_byte_type e;
      e.data   = b;
      e.first  = first;
      e.last   = last;
      e.length = cur_len;
      frame_expect_q.push_back(e);
   endfunction

   // predictor: advance the parser by one accepted byte
   function automatic void parse_byte(input logic [7:0] b);
      logic [afd_pkg::LenW-1:0] len;
      case (parse_phase)
         IN_HEADER: begin
            if (hdr_count == 1) begin
               if ((b & afd_pkg::SyncHiMask) == afd_pkg::SyncHiMask) begin
                  hdr_hold[1] = b;
                  hdr_count = 2;
               end else begin
                  parse_phase = HUNTING;
                  hdr_count = 0;
               end
            end else if (hdr_count >= 2 && hdr_count < afd_pkg::HdrBytes) begin
               hdr_hold[hdr_count] = b;
               hdr_count++;
               if (hdr_count == afd_pkg::HdrBytes) begin
                  len = {hdr_hold[3][1:0], hdr_hold[4], hdr_hold[5][7:5]};
                  hdr_count = 0;
                  if (len < afd_pkg::MinLen || len > max_len) begin
                     parse_phase = HUNTING;
                  end else begin
                     cur_len = len;
                     body_left = len - afd_pkg::LenW'(afd_pkg::HdrBytes);
                     for (int i = 0; i < afd_pkg::HdrBytes; i++) begin
                        expect_byte(hdr_hold[i], i == 0, 1'b0);
                     end
                     parse_phase = IN_BODY;
                  end
               end
            end else begin
               parse_phase = HUNTING;
               hdr_count = 0;
            end
         end
         IN_BODY: begin
            if (body_left > 0) body_left--;
            expect_byte(b, 1'b0, body_left == 0);
            if (body_left == 0) parse_phase = HUNTING;
         end
         default: begin
            parse_phase = HUNTING;
            if (b == afd_pkg::SyncByte) begin
               hdr_hold[0] = b;
               hdr_count = 1;
               parse_phase = IN_HEADER;
            end
         end
      endcase
   endfunction

   // stream building: header with the length field, random filler elsewhere
   function automatic void add_header(input int unsigned len);
      logic [afd_pkg::LenW-1:0] l;
      logic [7:0]               r;
      l = afd_pkg::LenW'(len);
      r = 8'($urandom);
      stream_q.push_back(afd_pkg::SyncByte);
      stream_q.push_back(afd_pkg::SyncHiMask | {4'h0, r[3:0]});
      stream_q.push_back(8'($urandom));
      stream_q.push_back({r[7:2], l[12:11]});
      stream_q.push_back(l[10:3]);
      stream_q.push_back({l[2:0], 5'($urandom)});
   endfunction

   function automatic void add_frame(input int unsigned len);
      add_header(len);
      for (int unsigned i = afd_pkg::HdrBytes; i < len; i++) begin
         stream_q.push_back(8'($urandom));
      end
   endfunction

   // sync byte followed by a byte without the high nibble set
   function automatic void add_broken_sync();
      stream_q.push_back(afd_pkg::SyncByte);
      stream_q.push_back({4'($urandom_range(0, 14)), 4'($urandom)});
   endfunction

   // send one byte, with bursts and random gaps on the request side
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_byte(b);
   endtask

   task automatic send_stream();
      while (stream_q.size() != 0) begin
         send_byte(stream_q.pop_front());
      end
   endtask

   task automatic wait_drain();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      while (frame_expect_q.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // limit register writes only once the block has gone quiet
   task automatic write_max_len(input logic [afd_pkg::LenW-1:0] v);
      wait_drain();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      max_len = v;
   endtask

   // response side: random stall runs, or a long hold when asked
   initial begin
      bit          stall_now;
      int unsigned stall_run;
      stall_now = 1'b0;
      stall_run = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (stall_pct == 0) begin
            rsp_stall <= 1'b0;
         end else begin
            if (stall_run == 0) begin
               stall_now = ($urandom_range(0, 99) < stall_pct);
               stall_run = $urandom_range(1, 6);
            end
            stall_run--;
            rsp_stall <= stall_now;
         end
      end
   end

   // check every output transfer against the oldest prediction
   always @(posedge clock) begin : check_results
      frame_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_expect_q.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer, byte %h", rsp_frame_byte));
         end else begin
            want = frame_expect_q.pop_front();
            if (rsp_frame_byte !== want.data)
               report_mismatch($sformatf("frame_byte %h, want %h",
                                         rsp_frame_byte, want.data));
            if (rsp_first_of_frame !== want.first)
               report_mismatch($sformatf("first_of_frame %b, want %b",
                                         rsp_first_of_frame, want.first));
            if (rsp_last_of_frame !== want.last)
               report_mismatch($sformatf("last_of_frame %b, want %b",
                                         rsp_last_of_frame, want.last));
            if (rsp_length_of_frame !== want.length)
               report_mismatch($sformatf("length_of_frame %0d, want %0d",
                                         rsp_length_of_frame, want.length));
         end
      end
   end

   // shortest frame, bad second byte, short length, special body bytes
   task automatic test_sync_and_lengths();
      gap_max = 3;
      stall_pct = 25;
      add_frame(7);
      add_broken_sync();
      add_header(6);
      add_header(9);
      stream_q.push_back(8'h00);
      stream_q.push_back(afd_pkg::SyncByte);
      stream_q.push_back(8'h55);
      send_stream();
   endtask

   // limit register: boundaries, all-reject setting and the widest limit
   task automatic test_max_setting();
      write_max_len(afd_pkg::LenW'(7));
      add_frame(7);
      add_header(8);
      send_stream();
      write_max_len(afd_pkg::LenW'(6));
      add_header(7);
      add_frame(20);
      send_stream();
      write_max_len(afd_pkg::LenW'(8191));
      gap_max = 0;
      stall_pct = 0;
      add_frame(40);
      send_stream();
      write_max_len(afd_pkg::LenW'(8190));
      add_header(8191);
      add_frame(12);
      send_stream();
      write_max_len(afd_pkg::MaxLenReset);
      add_header(5121);
      add_frame(20);
      send_stream();
   endtask

   // hold the output long enough that the block stalls its input
   task automatic test_backpressure();
      gap_max = 0;
      stall_pct = 0;
      hold_cycles = 200;
      for (int i = 0; i < 4; i++) add_frame(20);
      send_stream();
      wait_drain();
      gap_max = 4;
      stall_pct = 40;
      hold_cycles = 150;
      for (int i = 0; i < 3; i++) add_frame($urandom_range(7, 30));
      send_stream();
      wait_drain();
   endtask

   // random stream: mostly good frames, some noise and rejected headers
   task automatic test_random_stream();
      int unsigned framed;
      int unsigned iter;
      int unsigned len;
      int unsigned pick;
      int unsigned cap;
      framed = 0;
      iter = 0;
      while (framed < RandomItems) begin
         if (iter % 25 == 0) begin
            case ($urandom_range(0, 4))
               0:       write_max_len(afd_pkg::MaxLenReset);
               1:       write_max_len(afd_pkg::LenW'(7));
               2:       write_max_len(afd_pkg::LenW'(8191));
               3:       write_max_len(afd_pkg::LenW'($urandom_range(8, 48)));
               default: write_max_len(afd_pkg::LenW'(6));
            endcase
            case ($urandom_range(0, 2))
               0:       gap_max = 0;
               1:       gap_max = 2;
               default: gap_max = 6;
            endcase
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 25;
               default: stall_pct = 60;
            endcase
         end
         iter++;
         pick = $urandom_range(0, 99);
         if (pick < 70 && max_len >= afd_pkg::MinLen) begin
            cap = ($urandom_range(0, 19) == 0) ? 300 : 40;
            if (cap > max_len) cap = max_len;
            len = $urandom_range(afd_pkg::MinLen, cap);
            add_frame(len);
            framed += len;
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 4)) stream_q.push_back(8'($urandom_range(0, 254)));
         end else if (pick < 90) begin
            add_broken_sync();
         end else if (max_len < afd_pkg::MinLen) begin
            add_header($urandom_range(0, 8191));
         end else if (max_len == 8191 || $urandom_range(0, 1) == 0) begin
            add_header($urandom_range(0, afd_pkg::MinLen - 1));
         end else begin
            cap = max_len + 100;
            if (cap > 8191) cap = 8191;
            add_header($urandom_range(max_len + 1, cap));
         end
         send_stream();
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = 8'h00;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      parse_phase   = HUNTING;
      hdr_count     = 0;
      body_left     = '0;
      cur_len       = '0;
      max_len       = afd_pkg::MaxLenReset;
      mismatch_count = 0;
      gap_max       = 0;
      burst_left    = 0;
      stall_pct     = 0;
      hold_cycles   = 0;
      for (int i = 0; i < afd_pkg::HdrBytes; i++) hdr_hold[i] = 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_sync_and_lengths();
      test_max_setting();
      test_backpressure();
      test_random_stream();

      // let the last bytes drain out, then a little longer
      wait_drain();
      repeat (8) @(posedge clock);
      if (frame_expect_q.size() != 0) begin
         report_mismatch($sformatf("%0d predicted bytes never came out",
                                   frame_expect_q.size()));
      end
      if (mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // hang guard
   initial begin
      #60000000;
      $display("tb_top failed");
      $finish;
   end

endmodule

[files.f]
sv/afd_pkg.sv
sv/afd_front.sv
sv/afd_queue.sv
sv/afd_back.sv
sv/adts_frame_deframer.sv
tb/tb_top.sv
